/* src/spt_pkg.sv */
// shared types, constants and the cordic angle table for the stanley path tracker
// no dependencies
`default_nettype none
package spt_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int WP_W       = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_SPEED = 3'd0,
    CFG_GAIN_P       = 3'd1,
    CFG_GAIN_I       = 3'd2,
    CFG_GAIN_D       = 3'd3,
    CFG_STEER_GAIN   = 3'd4,
    CFG_ORIGIN_LON   = 3'd5,
    CFG_ORIGIN_LAT   = 3'd6,
    CFG_PATH_LENGTH  = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_WP_WRITE = 2'd0,
    KIND_STATUS   = 2'd1,
    KIND_FIX      = 2'd2,
    KIND_TICK     = 2'd3
  } kind_t;

  localparam logic [7:0] MODE_AUTO_A = 8'd1;
  localparam logic [7:0] MODE_AUTO_B = 8'd3;

  localparam logic signed [18:0] X_SCALE     = 19'sd147040;
  localparam logic signed [18:0] Y_SCALE     = 19'sd186621;
  localparam logic signed [16:0] HEAD_OFFSET = 17'sd5760;
  localparam logic [50:0]        LIMIT_SQ    = 51'd655360000;
  localparam logic signed [23:0] ACCEL_CAP   = 24'sd25600;
  localparam logic signed [13:0] STEER_CAP   = 14'sd7680;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [24:0] atan_lut(input logic [4:0] idx);
    logic signed [24:0] v;
    case (idx)
      5'd0:  v = 25'sd2949120;
      5'd1:  v = 25'sd1740967;
      5'd2:  v = 25'sd919879;
      5'd3:  v = 25'sd466945;
      5'd4:  v = 25'sd234379;
      5'd5:  v = 25'sd117304;
      5'd6:  v = 25'sd58666;
      5'd7:  v = 25'sd29335;
      5'd8:  v = 25'sd14668;
      5'd9:  v = 25'sd7334;
      5'd10: v = 25'sd3667;
      5'd11: v = 25'sd1833;
      5'd12: v = 25'sd917;
      5'd13: v = 25'sd458;
      5'd14: v = 25'sd229;
      5'd15: v = 25'sd115;
      5'd16: v = 25'sd57;
      5'd17: v = 25'sd29;
      5'd18: v = 25'sd14;
      5'd19: v = 25'sd7;
      5'd20: v = 25'sd4;
      5'd21: v = 25'sd2;
      5'd22: v = 25'sd1;
      default: v = 25'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* src/spt_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none
module spt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/stanley_path_tracker_top.sv */
// stanley path tracker: waypoint table, gnss fix search, pid speed and stanley steer
// depends on spt_pkg and spt_ram
//
//  channel | ports                       | direction
//  --------+-----------------------------+-----------------------------
//  in      | in_valid, in_stall, in_*    | request in, one per item
//  out     | out_valid, out_stall, out_* | result out, one per request
//  cfg     | cfg_we, cfg_index, cfg_wdata| register write, no wait
//
// waypoint writes and status requests go straight to the output; a control tick runs
// the pid steps and then the cordic (one cordic step a cycle); a fix converts the
// position and then searches min(path_length, MAX_WAYPOINTS) entries: the search reads one table entry
// a cycle through the single read port of the waypoint ram.
// reset is synchronous; the table is not cleared. a new request is taken while a
// finished result waits on a stalled output.
`default_nettype none
module stanley_path_tracker_top #(
  parameter int MAX_WAYPOINTS = 1024,
  parameter int CORDIC_STEPS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [spt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [spt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   in_kind,
  input  wire logic [9:0]                   in_wp_index,
  input  wire logic signed [23:0]           in_wp_x,
  input  wire logic signed [23:0]           in_wp_y,
  input  wire logic signed [15:0]           in_wp_heading,
  input  wire logic signed [31:0]           in_longitude,
  input  wire logic signed [30:0]           in_latitude,
  input  wire logic signed [15:0]           in_fix_heading,
  input  wire logic [15:0]                  in_speed,
  input  wire logic [7:0]                   in_drive_mode,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [23:0]                out_accel_cmd,
  output logic signed [13:0]                out_steer_cmd,
  output logic                              out_gear_request,
  output logic                              out_steering_valid,
  output logic [9:0]                        out_nearest_index,
  output logic signed [24:0]                out_lateral_error,
  output logic signed [16:0]                out_heading_error,
  output logic signed [23:0]                out_pos_x,
  output logic signed [23:0]                out_pos_y
);

  import spt_pkg::*;

  localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int LW = $clog2(MAX_WAYPOINTS + 1);
  localparam int CW = (LW > 11) ? LW : 11;
  localparam int SW = $clog2(CORDIC_STEPS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_CONV_X, S_CONV_Y, S_CONV_Y2, S_SEARCH, S_RD_LAT, S_RD_HEAD,
    S_HEAD_DONE, S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_CORDIC, S_ST0, S_ST1,
    S_ST2, S_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic [15:0]        target_r, gain_p_r, gain_i_r, gain_d_r, steer_gain_r;
  logic signed [31:0] origin_lon_r;
  logic signed [30:0] origin_lat_r;
  logic [10:0]        path_len_r;

  // block state
  logic [9:0]         nearest_r;
  logic signed [23:0] vx_r, vy_r;
  logic signed [15:0] vh_r;
  logic signed [24:0] lat_err_r;
  logic signed [16:0] head_err_r;
  logic [15:0]        speed_r;
  logic [7:0]         mode_r;
  logic signed [16:0] prev_err_r;
  logic signed [31:0] integ_r;
  logic               steer_flag_r;

  // working registers
  logic signed [31:0] lon_r;
  logic signed [30:0] lat_r;
  logic signed [15:0] fix_head_r;
  logic signed [51:0] conv_prod_r;
  logic [CW-1:0]      len_r, iss_cnt_r;
  logic               rv1_r, rv2_r, rv3_r;
  logic [CW-1:0]      idx1_r, idx2_r, idx3_r;
  logic signed [24:0] dx_r, dy_r;
  logic [49:0]        sqx_r, sqy_r;
  logic [50:0]        best_r;
  logic signed [16:0] e_r;
  logic signed [17:0] d_r;
  logic signed [48:0] prod_r;
  logic signed [50:0] acc_r;
  logic signed [41:0] ymul_r;
  logic signed [49:0] cx_r, cy_r;
  logic signed [24:0] cz_r;
  logic [SW-1:0]      cord_i_r;
  logic [16:0]        st_u_r;
  logic [33:0]        st_q_r;
  logic signed [23:0] accel_res_r;
  logic signed [13:0] steer_res_r;

  // output register
  logic               out_valid_r;

  // waypoint ram
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [WP_W-1:0]    ram_wdata, ram_rdata;
  logic signed [23:0] ram_x, ram_y;
  logic signed [15:0] ram_h;

  spt_ram #(.WIDTH(WP_W), .DEPTH(MAX_WAYPOINTS)) u_wp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic in_acc, out_free, autom;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign autom    = (mode_r == MODE_AUTO_A) || (mode_r == MODE_AUTO_B);

  assign ram_we    = in_acc && (in_kind == KIND_WP_WRITE) &&
                     (32'(in_wp_index) < 32'(MAX_WAYPOINTS));
  assign ram_waddr = AW'(in_wp_index);
  assign ram_wdata = {in_wp_x, in_wp_y, in_wp_heading};
  assign ram_x     = $signed(ram_rdata[63:40]);
  assign ram_y     = $signed(ram_rdata[39:16]);
  assign ram_h     = $signed(ram_rdata[15:0]);

  // fix conversion
  logic signed [32:0] dlon_c;
  logic signed [31:0] dlat_c;
  logic signed [51:0] conv_x_c, conv_y_c, conv_sum_c;
  logic signed [35:0] conv_rnd_c;
  logic signed [23:0] conv_sat_c;
  logic signed [16:0] head_sum_c;
  logic signed [15:0] head_sat_c;
  assign dlon_c     = $signed({lon_r[31], lon_r}) - $signed({origin_lon_r[31], origin_lon_r});
  assign dlat_c     = $signed({lat_r[30], lat_r}) - $signed({origin_lat_r[30], origin_lat_r});
  assign conv_x_c   = dlon_c * X_SCALE;
  assign conv_y_c   = dlat_c * Y_SCALE;
  assign conv_sum_c = conv_prod_r + 52'sd32768;
  assign conv_rnd_c = conv_sum_c[51:16];
  assign conv_sat_c = (conv_rnd_c > 36'sd8388607)  ? 24'sd8388607 :
                      (conv_rnd_c < -36'sd8388608) ? -24'sd8388608 : conv_rnd_c[23:0];
  assign head_sum_c = $signed({fix_head_r[15], fix_head_r}) + HEAD_OFFSET;
  assign head_sat_c = (head_sum_c > 17'sd32767)  ? 16'sd32767 :
                      (head_sum_c < -17'sd32768) ? -16'sd32768 : head_sum_c[15:0];

  // search and target reads
  logic [CW-1:0] len_c;
  logic [50:0]   dist_c;
  logic [CW:0]   last_c, ti_lat_c, ti_head_c, n2_c, n5_c;
  assign len_c     = (CW'(path_len_r) > CW'(MAX_WAYPOINTS)) ? CW'(MAX_WAYPOINTS)
                                                           : CW'(path_len_r);
  assign dist_c    = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign last_c    = (len_r == '0) ? '0 : ((CW+1)'(len_r) - 1'b1);
  assign n2_c      = (CW+1)'(nearest_r) + (CW+1)'(2);
  assign n5_c      = (CW+1)'(nearest_r) + (CW+1)'(5);
  assign ti_lat_c  = (n2_c > last_c) ? last_c : n2_c;
  assign ti_head_c = (n5_c > last_c) ? last_c : n5_c;

  always_comb begin
    case (state_r)
      S_RD_LAT:  ram_raddr = AW'(ti_lat_c);
      S_RD_HEAD: ram_raddr = AW'(ti_head_c);
      default:   ram_raddr = AW'(iss_cnt_r);
    endcase
  end

  // pid
  logic signed [16:0] e_c;
  logic signed [32:0] integ_sum_c;
  logic signed [50:0] acc_sum_c;
  logic signed [38:0] acc_rnd_c;
  assign e_c         = $signed({1'b0, target_r}) - $signed({1'b0, speed_r});
  assign integ_sum_c = (autom ? 33'(integ_r) : 33'sd0) + 33'(e_c);
  assign acc_sum_c   = acc_r + 51'sd2048;
  assign acc_rnd_c   = acc_sum_c[50:12];

  // cordic step
  logic signed [49:0] cxs_c, cys_c;
  assign cxs_c = cx_r >>> cord_i_r;
  assign cys_c = cy_r >>> cord_i_r;

  // steer rounding: floor((n + 640) / 1280) as floor(m / 5) with m = (n + 640) >> 8
  logic signed [31:0] st_n_c;
  logic signed [23:0] st_m_c;
  logic signed [16:0] st_mc_c;
  logic signed [15:0] st_q_c;
  assign st_n_c  = (32'(head_err_r) * 32'sd4096) + (32'(cz_r) * 32'sd5) + 32'sd640;
  assign st_m_c  = st_n_c[31:8];
  assign st_mc_c = (st_m_c > 24'sd38405)  ? 17'sd38405 :
                   (st_m_c < -24'sd38405) ? -17'sd38405 : st_m_c[16:0];
  assign st_q_c  = $signed({1'b0, st_q_r[32:18]}) - 16'sd7681;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      target_r     <= 16'd2048;
      gain_p_r     <= 16'd12288;
      gain_i_r     <= 16'd41;
      gain_d_r     <= 16'd0;
      steer_gain_r <= 16'd410;
      origin_lon_r <= 32'sd1163108713;
      origin_lat_r <= 31'sd399558476;
      path_len_r   <= '0;
      nearest_r    <= '0;
      vx_r         <= '0;
      vy_r         <= '0;
      vh_r         <= '0;
      lat_err_r    <= '0;
      head_err_r   <= '0;
      speed_r      <= '0;
      mode_r       <= '0;
      prev_err_r   <= '0;
      integ_r      <= '0;
      steer_flag_r <= 1'b0;
      rv1_r        <= 1'b0;
      rv2_r        <= 1'b0;
      rv3_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TARGET_SPEED: target_r     <= cfg_wdata[15:0];
          CFG_GAIN_P:       gain_p_r     <= cfg_wdata[15:0];
          CFG_GAIN_I:       gain_i_r     <= cfg_wdata[15:0];
          CFG_GAIN_D:       gain_d_r     <= cfg_wdata[15:0];
          CFG_STEER_GAIN:   steer_gain_r <= cfg_wdata[15:0];
          CFG_ORIGIN_LON:   origin_lon_r <= $signed(cfg_wdata);
          CFG_ORIGIN_LAT:   origin_lat_r <= $signed(cfg_wdata[30:0]);
          CFG_PATH_LENGTH:  path_len_r   <= cfg_wdata[10:0];
          default: ;
        endcase
      end

      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      // search pipeline: ram data, differences, squares, compare
      rv1_r  <= (state_r == S_SEARCH) && (iss_cnt_r < len_r);
      rv2_r  <= rv1_r;
      rv3_r  <= rv2_r;
      idx2_r <= idx1_r;
      idx3_r <= idx2_r;
      dx_r   <= $signed({vx_r[23], vx_r}) - $signed({ram_x[23], ram_x});
      dy_r   <= $signed({vy_r[23], vy_r}) - $signed({ram_y[23], ram_y});
      sqx_r  <= 50'(dx_r * dx_r);
      sqy_r  <= 50'(dy_r * dy_r);
      if (rv3_r && (dist_c < best_r)) begin
        best_r    <= dist_c;
        nearest_r <= 10'(idx3_r);
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            accel_res_r <= '0;
            steer_res_r <= '0;
            lon_r       <= in_longitude;
            lat_r       <= in_latitude;
            fix_head_r  <= in_fix_heading;
            case (kind_t'(in_kind))
              KIND_STATUS: begin
                speed_r <= in_speed;
                mode_r  <= in_drive_mode;
                state_r <= S_OUT;
              end
              KIND_FIX:  state_r <= S_CONV_X;
              KIND_TICK: state_r <= S_T0;
              default:   state_r <= S_OUT;
            endcase
          end
        end
        S_CONV_X: begin
          conv_prod_r <= conv_x_c;
          state_r     <= S_CONV_Y;
        end
        S_CONV_Y: begin
          vx_r        <= conv_sat_c;
          vh_r        <= head_sat_c;
          conv_prod_r <= conv_y_c;
          state_r     <= S_CONV_Y2;
        end
        S_CONV_Y2: begin
          vy_r      <= conv_sat_c;
          len_r     <= len_c;
          iss_cnt_r <= '0;
          best_r    <= LIMIT_SQ;
          state_r   <= S_SEARCH;
        end
        S_SEARCH: begin
          if (iss_cnt_r < len_r) begin
            idx1_r    <= iss_cnt_r;
            iss_cnt_r <= iss_cnt_r + 1'b1;
          end else if (!rv1_r && !rv2_r && !rv3_r) begin
            state_r <= S_RD_LAT;
          end
        end
        S_RD_LAT:  state_r <= S_RD_HEAD;
        S_RD_HEAD: begin
          lat_err_r <= $signed({ram_y[23], ram_y}) - $signed({vy_r[23], vy_r});
          state_r   <= S_HEAD_DONE;
        end
        S_HEAD_DONE: begin
          head_err_r <= $signed({ram_h[15], ram_h}) - $signed({vh_r[15], vh_r});
          state_r    <= S_OUT;
        end
        S_T0: begin
          e_r        <= e_c;
          d_r        <= 18'(prev_err_r) - 18'(e_c);
          prev_err_r <= e_c;
          integ_r    <= (integ_sum_c > 33'sd2147483647)  ? 32'sd2147483647 :
                        (integ_sum_c < -33'sd2147483648) ? -32'sd2147483648 :
                        integ_sum_c[31:0];
          if (autom) begin
            steer_flag_r <= 1'b1;
          end
          state_r <= S_T1;
        end
        S_T1: begin
          prod_r  <= $signed({1'b0, gain_p_r}) * e_r;
          ymul_r  <= $signed({1'b0, steer_gain_r}) * lat_err_r;
          state_r <= S_T2;
        end
        S_T2: begin
          acc_r   <= 51'(prod_r);
          prod_r  <= $signed({1'b0, gain_i_r}) * integ_r;
          state_r <= S_T3;
        end
        S_T3: begin
          acc_r   <= acc_r + 51'(prod_r);
          prod_r  <= $signed({1'b0, gain_d_r}) * d_r;
          state_r <= S_T4;
        end
        S_T4: begin
          acc_r   <= acc_r + 51'(prod_r);
          state_r <= S_T5;
        end
        S_T5: begin
          accel_res_r <= (acc_rnd_c > 39'(ACCEL_CAP))  ? ACCEL_CAP :
                         (acc_rnd_c < -39'sd8388608)   ? -24'sd8388608 : acc_rnd_c[23:0];
          cx_r     <= $signed(50'(target_r)) * 50'sd40960;
          cy_r     <= 50'(ymul_r) * 50'sd36;
          cz_r     <= '0;
          cord_i_r <= '0;
          // zero cross-track gives exactly zero angle
          state_r  <= (ymul_r == '0) ? S_ST0 : S_CORDIC;
        end
        S_CORDIC: begin
          if (!cy_r[49]) begin
            cx_r <= cx_r + cys_c;
            cy_r <= cy_r - cxs_c;
            cz_r <= cz_r + atan_lut(5'(cord_i_r));
          end else begin
            cx_r <= cx_r - cys_c;
            cy_r <= cy_r + cxs_c;
            cz_r <= cz_r - atan_lut(5'(cord_i_r));
          end
          cord_i_r <= cord_i_r + 1'b1;
          if (cord_i_r == SW'(CORDIC_STEPS - 1)) begin
            state_r <= S_ST0;
          end
        end
        S_ST0: begin
          st_u_r  <= 17'(st_mc_c + 17'sd38405);
          state_r <= S_ST1;
        end
        S_ST1: begin
          // divide by 5 through the reciprocal 52429 / 2^18
          st_q_r  <= 34'(st_u_r) * 34'd52429;
          state_r <= S_ST2;
        end
        S_ST2: begin
          steer_res_r <= (st_q_c > 16'(STEER_CAP))  ? STEER_CAP :
                         (st_q_c < -16'(STEER_CAP)) ? -STEER_CAP : st_q_c[13:0];
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_accel_cmd      <= accel_res_r;
            out_steer_cmd      <= steer_res_r;
            out_gear_request   <= autom;
            out_steering_valid <= steer_flag_r;
            out_nearest_index  <= nearest_r;
            out_lateral_error  <= lat_err_r;
            out_heading_error  <= head_err_r;
            out_pos_x          <= vx_r;
            out_pos_y          <= vy_r;
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

/* tb/stanley_path_tracker_top_tb.sv */
// testbench for stanley_path_tracker_top: random and directed requests checked
// against a local fixed-point predictor; depends on spt_pkg and the tracker rtl
`timescale 1ns / 100ps
module stanley_path_tracker_top_tb;
  import spt_pkg::*;

  typedef struct {
    kind_t                kind;
    logic [9:0]           wp_index;
    logic signed [23:0]   wp_x, wp_y;
    logic signed [15:0]   wp_heading;
    logic signed [31:0]   longitude;
    logic signed [30:0]   latitude;
    logic signed [15:0]   fix_heading;
    logic [15:0]          speed;
    logic [7:0]           drive_mode;
    bit                   drain;   // hold this request until all results are back
  } req_t;

  typedef struct packed {
    logic signed [23:0] accel;
    logic signed [13:0] steer;
    logic               gear;
    logic               sval;
    logic [9:0]         near;
    logic signed [24:0] lat;
    logic signed [16:0] head;
    logic signed [23:0] px;
    logic signed [23:0] py;
  } ctrl_out_t;

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 0, in_stall;
  logic [1:0] in_kind = '0;
  logic [9:0] in_wp_index = '0;
  logic signed [23:0] in_wp_x = '0, in_wp_y = '0;
  logic signed [15:0] in_wp_heading = '0;
  logic signed [31:0] in_longitude = '0;
  logic signed [30:0] in_latitude = '0;
  logic signed [15:0] in_fix_heading = '0;
  logic [15:0] in_speed = '0;
  logic [7:0] in_drive_mode = '0;
  logic out_valid, out_stall = 0;
  logic signed [23:0] out_accel_cmd, out_pos_x, out_pos_y;
  logic signed [13:0] out_steer_cmd;
  logic out_gear_request, out_steering_valid;
  logic [9:0] out_nearest_index;
  logic signed [24:0] out_lateral_error;
  logic signed [16:0] out_heading_error;

  stanley_path_tracker_top dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // predictor state
  longint wpx[1024], wpy[1024], wph[1024];
  longint tgt_spd = 2048, kp = 12288, ki = 41, kd = 0, ks = 410;
  longint org_lon = 1163108713, org_lat = 399558476, path_len = 0;
  int     near_idx = 0;
  longint veh_x = 0, veh_y = 0, veh_h = 0, lat_err = 0, head_err = 0;
  longint spd = 0, mode = 0, prev_err = 0, integ = 0;
  bit     steer_ok = 0;

  const longint atan_deg[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                 58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                 229, 115};

  req_t      pending[$];
  ctrl_out_t expected_out[$];
  int        errors = 0, results_seen = 0;
  int        kind_cnt[4] = '{0, 0, 0, 0};
  bit        calm = 0, hold_ask = 0;
  int        hold_left = 0;
  int        filled = 0;

  function automatic void add_req(req_t r);
    pending = {pending, r};
  endfunction

  function automatic longint floor_div(longint a, longint d);
    longint q = a / d;
    if (a % d != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint round_div(longint n, longint d);
    return floor_div(2 * n + d, 2 * d);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint atan_cordic(longint y, longint x);
    longint z = 0, xs, ys;
    if (y == 0) return 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_deg[i];
      end else begin
        x -= ys; y += xs; z -= atan_deg[i];
      end
    end
    return z;
  endfunction

  function automatic ctrl_out_t track_step(req_t r);
    ctrl_out_t o;
    longint accel = 0, steer = 0, e, d, best, dx, dy, sqd;
    int len, last, ti;
    bit autom;
    case (r.kind)
      KIND_WP_WRITE: begin
        wpx[r.wp_index] = longint'(r.wp_x);
        wpy[r.wp_index] = longint'(r.wp_y);
        wph[r.wp_index] = longint'(r.wp_heading);
      end
      KIND_STATUS: begin
        spd = longint'(r.speed);
        mode = longint'(r.drive_mode);
      end
      KIND_FIX: begin
        len = path_len > 1024 ? 1024 : int'(path_len);
        veh_x = clip(round_div((longint'(r.longitude) - org_lon) * 147040, 65536),
                     -8388608, 8388607);
        veh_y = clip(round_div((longint'(r.latitude) - org_lat) * 186621, 65536),
                     -8388608, 8388607);
        veh_h = clip(longint'(r.fix_heading) + 5760, -32768, 32767);
        best = 655360000;
        for (int b = 0; b < len; b++) begin
          dx = veh_x - wpx[b];
          dy = veh_y - wpy[b];
          sqd = dx * dx + dy * dy;
          if (sqd < best) begin
            best = sqd;
            near_idx = b;
          end
        end
        last = len == 0 ? 0 : len - 1;
        ti = near_idx + 2 > last ? last : near_idx + 2;
        lat_err = wpy[ti] - veh_y;
        ti = near_idx + 5 > last ? last : near_idx + 5;
        head_err = wph[ti] - veh_h;
      end
      default: ;
    endcase
    autom = (mode == MODE_AUTO_A || mode == MODE_AUTO_B);
    if (r.kind == KIND_TICK) begin
      e = tgt_spd - spd;
      d = prev_err - e;
      integ = clip((autom ? integ : 0) + e, -64'sd2147483648, 64'sd2147483647);
      prev_err = e;
      if (autom) steer_ok = 1;
      accel = clip(round_div(kp * e + ki * integ + kd * d, 4096), -8388608, 25600);
      steer = round_div(head_err * 4096 +
                        5 * atan_cordic(ks * lat_err * 36, 40960 * tgt_spd), 1280);
      steer = clip(steer, -7680, 7680);
    end
    o.accel = accel[23:0];
    o.steer = steer[13:0];
    o.gear  = autom;
    o.sval  = steer_ok;
    o.near  = near_idx[9:0];
    o.lat   = lat_err[24:0];
    o.head  = head_err[16:0];
    o.px    = veh_x[23:0];
    o.py    = veh_y[23:0];
    return o;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else begin
      automatic bit can_go;
      automatic req_t r;
      automatic bit taken = in_valid && !in_stall;
      if (taken) begin
        r.kind = kind_t'(in_kind); r.wp_index = in_wp_index;
        r.wp_x = in_wp_x; r.wp_y = in_wp_y; r.wp_heading = in_wp_heading;
        r.longitude = in_longitude; r.latitude = in_latitude;
        r.fix_heading = in_fix_heading; r.speed = in_speed;
        r.drive_mode = in_drive_mode;
        expected_out = {expected_out, track_step(r)};
        kind_cnt[in_kind]++;
      end
      if (!in_valid || taken) begin
        can_go = pending.size() > 0 && (calm || $urandom_range(99) >= 34);
        if (can_go && pending[0].drain && expected_out.size() > 0) can_go = 0;
        if (can_go) begin
          r = pending.pop_front();
          in_kind <= r.kind; in_wp_index <= r.wp_index;
          in_wp_x <= r.wp_x; in_wp_y <= r.wp_y; in_wp_heading <= r.wp_heading;
          in_longitude <= r.longitude; in_latitude <= r.latitude;
          in_fix_heading <= r.fix_heading; in_speed <= r.speed;
          in_drive_mode <= r.drive_mode;
        end
        in_valid <= can_go;
      end
    end
  end

  // result stall, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_ask) begin
      hold_left = 400;
      hold_ask = 0;
    end
    if (hold_left > 0) hold_left--;
    out_stall <= hold_left > 0 || (!calm && $urandom_range(99) < 34);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      automatic ctrl_out_t got = {out_accel_cmd, out_steer_cmd, out_gear_request,
                                  out_steering_valid, out_nearest_index,
                                  out_lateral_error, out_heading_error, out_pos_x,
                                  out_pos_y};
      results_seen++;
      if (expected_out.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        automatic ctrl_out_t exp_r = expected_out.pop_front();
        if (got !== exp_r) begin
          errors++;
          if (errors <= 10) $display("mismatch at result %0d\n  exp %p\n  got %p",
                                     results_seen, exp_r, got);
        end
      end
    end
  end

  function automatic longint srand(longint lo, longint hi);
    return lo + longint'($urandom_range(32'(hi - lo), 0));
  endfunction

  function automatic req_t rand_req(kind_t k);
    req_t r;
    r.kind = k;
    r.wp_index = 10'($urandom);
    r.wp_x = 24'($urandom); r.wp_y = 24'($urandom); r.wp_heading = 16'($urandom);
    r.longitude = 32'(srand(-1800000000, 1800000000));
    r.latitude = 31'(srand(-900000000, 900000000));
    r.fix_heading = 16'(srand(-23040, 23040));
    r.speed = 16'($urandom);
    r.drive_mode = $urandom_range(1) ? ($urandom_range(1) ? MODE_AUTO_A : MODE_AUTO_B)
                                     : 8'($urandom);
    r.drain = 0;
    return r;
  endfunction

  // fix near the configured origin, so the search finds waypoints
  function automatic req_t near_fix();
    req_t r = rand_req(KIND_FIX);
    r.longitude = 32'(clip(org_lon + srand(-20000, 20000), -1800000000, 1800000000));
    r.latitude = 31'(clip(org_lat + srand(-20000, 20000), -900000000, 900000000));
    return r;
  endfunction

  function automatic req_t wp_req(int idx);
    req_t r = rand_req(KIND_WP_WRITE);
    r.wp_index = idx[9:0];
    r.wp_x = 24'(srand(-50000, 50000));
    r.wp_y = 24'(srand(-60000, 60000));
    return r;
  endfunction

  task automatic wait_idle();
    while (pending.size() > 0 || expected_out.size() > 0 || in_valid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, longint v);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= 32'(v);
    case (idx)
      CFG_TARGET_SPEED: tgt_spd = v & 16'hffff;
      CFG_GAIN_P:       kp = v & 16'hffff;
      CFG_GAIN_I:       ki = v & 16'hffff;
      CFG_GAIN_D:       kd = v & 16'hffff;
      CFG_STEER_GAIN:   ks = v & 16'hffff;
      CFG_ORIGIN_LON:   org_lon = longint'($signed(32'(v)));
      CFG_ORIGIN_LAT:   org_lat = longint'($signed(31'(v)));
      default:          path_len = v & 11'h7ff;
    endcase
  endtask

  task automatic set_phase(longint ts, longint gp, longint gi, longint gd, longint sg,
                           longint lon, longint lat, longint pl);
    cfg_write(CFG_TARGET_SPEED, ts);
    cfg_write(CFG_GAIN_P, gp);
    cfg_write(CFG_GAIN_I, gi);
    cfg_write(CFG_GAIN_D, gd);
    cfg_write(CFG_STEER_GAIN, sg);
    cfg_write(CFG_ORIGIN_LON, lon);
    cfg_write(CFG_ORIGIN_LAT, lat);
    cfg_write(CFG_PATH_LENGTH, pl);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_phase(int n);
    int want = path_len > 1024 ? 1024 : int'(path_len);
    req_t r;
    // entries the search will read must be written first
    while (filled < want) begin
      add_req(wp_req(filled));
      filled++;
    end
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0, 1, 2: r = wp_req($urandom_range(1023));
        3, 4, 5, 6, 7: r = rand_req(KIND_STATUS);
        8: r = rand_req(KIND_FIX);
        9, 10, 11, 12, 13: r = near_fix();
        default: r = rand_req(KIND_TICK);
      endcase
      r.drain = (i == n / 2);
      add_req(r);
    end
  endtask

  initial begin
    req_t r;
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // directed: field extremes, every request kind, empty path
    r = wp_req(0); r.wp_x = 24'sh7fffff; r.wp_y = 24'sh800000; r.wp_heading = 16'sh8000;
    add_req(r);
    r = wp_req(1023); r.wp_x = 24'sh800000; r.wp_y = 24'sh7fffff;
    r.wp_heading = 16'sh7fff;
    add_req(r);
    r = rand_req(KIND_STATUS); r.drive_mode = MODE_AUTO_A; r.speed = 0;
    add_req(r);
    add_req(rand_req(KIND_TICK));
    r = rand_req(KIND_STATUS); r.drive_mode = MODE_AUTO_B; r.speed = 16'hffff;
    add_req(r);
    add_req(rand_req(KIND_TICK));
    r = rand_req(KIND_FIX); r.longitude = -1800000000; r.latitude = 900000000;
    r.fix_heading = -23040;
    add_req(r);
    add_req(rand_req(KIND_TICK));
    r = rand_req(KIND_FIX); r.longitude = 1800000000; r.latitude = -900000000;
    r.fix_heading = 23040;
    add_req(r);
    r = rand_req(KIND_STATUS); r.drive_mode = 8'd0;
    add_req(r);
    add_req(rand_req(KIND_TICK));
    r = rand_req(KIND_STATUS); r.drive_mode = 8'hff;
    add_req(r);
    add_req(near_fix());
    add_req(rand_req(KIND_TICK));
    filled = 1;
    wait_idle();

    set_phase(2048, 12288, 41, 0, 410, 1163108713, 399558476, 8);
    random_phase(80);
    wait_idle();

    // no idling on either side here
    calm = 1;
    set_phase(65535, 65535, 65535, 65535, 65535, 1800000000, 900000000, 40);
    random_phase(80);
    wait_idle();
    calm = 0;

    // long result hold-off while requests keep coming
    set_phase(1, 0, 0, 0, 0, -1800000000, -900000000, 40);
    hold_ask = 1;
    random_phase(80);
    wait_idle();

    set_phase(0, $urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
              $urandom_range(65535), 0, 0, 1);
    random_phase(80);
    wait_idle();

    set_phase($urandom_range(65535, 1), $urandom_range(65535), $urandom_range(65535),
              $urandom_range(65535), $urandom_range(65535), 1163108713, 399558476, 100);
    random_phase(80);
    wait_idle();

    // longer path with a derivative gain
    set_phase(3000, 12288, 41, 100, 410, 1163108713, 399558476, 120);
    random_phase(15);
    wait_idle();
    repeat (40) @(posedge clk);

    $display("checked %0d results: %0d waypoint writes, %0d status, %0d fixes, %0d ticks",
             results_seen, kind_cnt[0], kind_cnt[1], kind_cnt[2], kind_cnt[3]);
    $display("path lengths 0 to 120, gain and origin extremes, %0d errors", errors);
    if (errors == 0 && expected_out.size() == 0)
      $display("stanley_path_tracker_top verification clean");
    else
      $display("stanley_path_tracker_top verification failed");
    $finish;
  end

  initial begin
    #8000000;
    $display("stanley_path_tracker_top verification failed");
    $finish;
  end

endmodule

/* stanley_path_tracker_top.f */
src/spt_pkg.sv
src/spt_ram.sv
src/stanley_path_tracker_top.sv
tb/stanley_path_tracker_top_tb.sv
